// ----- rtl/idxq_pkg.sv -----
// ----------------------------------------------------------------------------
// Index allocator package
// Shared types and constants for the index allocator with reuse queue.
// ----------------------------------------------------------------------------
package idxq_pkg;

  localparam int INDEX_BITS_DEFAULT = 10;
  localparam int ARRAY_SIZE_W       = 11;
  localparam int STATUS_W           = 3;

  // Request mode carried on in_mode.
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK              = 3'd0,
    ST_ARRAY_REACHED   = 3'd1,
    ST_SPACE_EXHAUSTED = 3'd2,
    ST_ALLOC_REFUSED   = 3'd3,
    ST_RELEASE_REFUSED = 3'd4
  } status_t;

  typedef enum logic {
    CORE_IDLE,
    CORE_EMIT
  } core_state_t;

  // Control strobes from the core to the queue memory.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// ----- rtl/idxq_mem.sv -----
// ----------------------------------------------------------------------------
// Release queue memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module idxq_mem
  import idxq_pkg::*;
#(
  parameter int ADDR_W = INDEX_BITS_DEFAULT,
  parameter int DATA_W = INDEX_BITS_DEFAULT
) (
  input  logic              clk,
  input  mem_ctl_t          ctl,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/idxq_core.sv -----
// ----------------------------------------------------------------------------
// Index allocator core
// Queue pointers, counters, allocate and release decisions, result staging.
// ----------------------------------------------------------------------------
module idxq_core
  import idxq_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [ARRAY_SIZE_W-1:0] cfg_wr_data,
  input  logic                    in_valid,
  input  logic                    in_mode,
  input  logic [INDEX_BITS-1:0]   in_released_index,
  output logic                    in_stall,
  output mem_ctl_t                mem_ctl,
  output logic [INDEX_BITS-1:0]   mem_wr_addr,
  output logic [INDEX_BITS-1:0]   mem_wr_data,
  output logic [INDEX_BITS-1:0]   mem_rd_addr,
  input  logic [INDEX_BITS-1:0]   mem_rd_data,
  output logic                    emit_valid,
  input  logic                    emit_take,
  output logic [INDEX_BITS-1:0]   res_granted_index,
  output logic                    res_reused,
  output status_t                 res_status,
  output logic [INDEX_BITS:0]     res_active_count
);

  localparam int CNT_W = INDEX_BITS + 1;
  localparam int CMP_W = (CNT_W > ARRAY_SIZE_W) ? CNT_W : ARRAY_SIZE_W;
  localparam logic [CNT_W-1:0] SPACE = CNT_W'(1) << INDEX_BITS;

  core_state_t             state_r, state_nxt;
  logic [INDEX_BITS-1:0]   head_r, head_nxt;
  logic [INDEX_BITS-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic [CNT_W-1:0]        fresh_r, fresh_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [ARRAY_SIZE_W-1:0] array_size_r, array_size_nxt;
  logic [INDEX_BITS-1:0]   pend_idx_r, pend_idx_nxt;
  logic                    pend_reused_r, pend_reused_nxt;
  status_t                 pend_status_r, pend_status_nxt;
  logic [CNT_W-1:0]        pend_count_r, pend_count_nxt;

  logic             accept;
  logic [CNT_W-1:0] fresh_inc;

  assign accept    = in_valid && !in_stall;
  assign fresh_inc = fresh_r + CNT_W'(1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CORE_IDLE: begin
        if (accept) begin
          state_nxt = CORE_EMIT;
        end
      end
      CORE_EMIT: begin
        if (emit_take) begin
          state_nxt = CORE_IDLE;
        end
      end
      default: state_nxt = CORE_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall   = 1'b1;
    emit_valid = 1'b0;
    unique case (state_r)
      CORE_IDLE: in_stall   = 1'b0;
      CORE_EMIT: emit_valid = 1'b1;
      default: begin
        in_stall   = 1'b1;
        emit_valid = 1'b0;
      end
    endcase
  end

  // Allocate and release decisions; all counter updates happen in the
  // accepting cycle, only the reused index arrives in the cycle after.
  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    fill_nxt        = fill_r;
    fresh_nxt       = fresh_r;
    count_nxt       = count_r;
    array_size_nxt  = cfg_wr_en ? cfg_wr_data : array_size_r;
    pend_idx_nxt    = pend_idx_r;
    pend_reused_nxt = pend_reused_r;
    pend_status_nxt = pend_status_r;
    pend_count_nxt  = pend_count_r;
    mem_ctl         = '0;
    mem_wr_addr     = tail_r;
    mem_wr_data     = in_released_index;
    mem_rd_addr     = head_r;

    if (accept) begin
      pend_idx_nxt    = '0;
      pend_reused_nxt = 1'b0;
      pend_status_nxt = ST_OK;
      if (in_mode == MODE_ALLOC) begin
        if (fill_r != '0) begin
          mem_ctl.rd_en   = 1'b1;
          head_nxt        = head_r + INDEX_BITS'(1);
          fill_nxt        = fill_r - CNT_W'(1);
          count_nxt       = count_r + CNT_W'(1);
          pend_reused_nxt = 1'b1;
        end else if (fresh_r[INDEX_BITS]) begin
          pend_status_nxt = ST_ALLOC_REFUSED;
        end else begin
          pend_idx_nxt = fresh_r[INDEX_BITS-1:0];
          fresh_nxt    = fresh_inc;
          count_nxt    = count_r + CNT_W'(1);
          if (fresh_inc == SPACE) begin
            pend_status_nxt = ST_SPACE_EXHAUSTED;
          end else if ((array_size_r != '0) &&
                       (CMP_W'(fresh_inc) == CMP_W'(array_size_r))) begin
            pend_status_nxt = ST_ARRAY_REACHED;
          end
        end
      end else begin
        if ((count_r == '0) || fill_r[INDEX_BITS]) begin
          pend_status_nxt = ST_RELEASE_REFUSED;
        end else begin
          mem_ctl.wr_en = 1'b1;
          tail_nxt      = tail_r + INDEX_BITS'(1);
          fill_nxt      = fill_r + CNT_W'(1);
          count_nxt     = count_r - CNT_W'(1);
        end
      end
      pend_count_nxt = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= CORE_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      fill_r       <= '0;
      fresh_r      <= '0;
      count_r      <= '0;
      array_size_r <= '0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      fill_r       <= fill_nxt;
      fresh_r      <= fresh_nxt;
      count_r      <= count_nxt;
      array_size_r <= array_size_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r    <= pend_idx_nxt;
    pend_reused_r <= pend_reused_nxt;
    pend_status_r <= pend_status_nxt;
    pend_count_r  <= pend_count_nxt;
  end

  // The memory read data holds until the next read, which cannot start
  // before this result has been handed over.
  assign res_granted_index = pend_reused_r ? mem_rd_data : pend_idx_r;
  assign res_reused        = pend_reused_r;
  assign res_status        = pend_status_r;
  assign res_active_count  = pend_count_r;

endmodule

// ----- rtl/index_allocator_with_reuse_queue_unit.sv -----
// ----------------------------------------------------------------------------
// Index allocator with reuse queue
// Hands out slot indices, oldest released first, then fresh ones.
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_stall   in_mode, in_released_index
//   out_     output     out_valid/out_stall out_granted_index, out_reused,
//                                           out_status, out_active_count
//   cfg_     input      cfg_wr_en           cfg_wr_data (array size)
//
// Each transaction passes through the core states CORE_IDLE and CORE_EMIT:
// the accepting cycle updates the counters and starts the queue memory read
// or write, and in CORE_EMIT the result moves into the output register once
// that is free. No new transaction is taken until the result has moved.
// Reset is synchronous; the queue memory is not cleared.
// While out_stall holds a result in the output register, the core keeps the
// next result waiting and in_stall stays high.
// ----------------------------------------------------------------------------
module index_allocator_with_reuse_queue_unit
  import idxq_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [ARRAY_SIZE_W-1:0] cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_mode,
  input  logic [INDEX_BITS-1:0]   in_released_index,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [INDEX_BITS-1:0]   out_granted_index,
  output logic                    out_reused,
  output logic [STATUS_W-1:0]     out_status,
  output logic [INDEX_BITS:0]     out_active_count
);

  mem_ctl_t              mem_ctl;
  logic [INDEX_BITS-1:0] mem_wr_addr;
  logic [INDEX_BITS-1:0] mem_wr_data;
  logic [INDEX_BITS-1:0] mem_rd_addr;
  logic [INDEX_BITS-1:0] mem_rd_data;

  logic                  emit_valid;
  logic                  emit_take;
  logic [INDEX_BITS-1:0] res_granted_index;
  logic                  res_reused;
  status_t               res_status;
  logic [INDEX_BITS:0]   res_active_count;

  logic                  out_valid_r, out_valid_nxt;
  logic [INDEX_BITS-1:0] out_granted_r;
  logic                  out_reused_r;
  status_t               out_status_r;
  logic [INDEX_BITS:0]   out_count_r;

  idxq_mem #(
    .ADDR_W (INDEX_BITS),
    .DATA_W (INDEX_BITS)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  idxq_core #(
    .INDEX_BITS (INDEX_BITS)
  ) u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_mode           (in_mode),
    .in_released_index (in_released_index),
    .in_stall          (in_stall),
    .mem_ctl           (mem_ctl),
    .mem_wr_addr       (mem_wr_addr),
    .mem_wr_data       (mem_wr_data),
    .mem_rd_addr       (mem_rd_addr),
    .mem_rd_data       (mem_rd_data),
    .emit_valid        (emit_valid),
    .emit_take         (emit_take),
    .res_granted_index (res_granted_index),
    .res_reused        (res_reused),
    .res_status        (res_status),
    .res_active_count  (res_active_count)
  );

  // Output register loads when empty or when its transaction completes.
  assign emit_take = emit_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_take) begin
      out_granted_r <= res_granted_index;
      out_reused_r  <= res_reused;
      out_status_r  <= res_status;
      out_count_r   <= res_active_count;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_granted_index = out_granted_r;
  assign out_reused        = out_reused_r;
  assign out_status        = out_status_r;
  assign out_active_count  = out_count_r;

  // A transaction is never accepted in the cycle right after another one.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while the previous transaction is in flight");

  // An index from the queue is always granted with plain status.
  a_reused_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reused) |-> (out_status == ST_OK))
    else $error("reused index reported with a warning or refusal");

  // Refusals and releases never carry an index.
  a_refused_no_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_ALLOC_REFUSED ||
                   out_status == ST_RELEASE_REFUSED))
      |-> (out_granted_index == '0 && !out_reused))
    else $error("refused transaction carries an index");

  // Results are only staged while the core has a finished transaction.
  a_load_from_core: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid)) |-> $past(emit_valid))
    else $error("output register loaded without a core result");

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Index allocator with reuse queue testbench
// Drives allocate and release transactions through the valid/stall input
// channel and predicts every result: reuse of the oldest released index,
// fresh indices, the array size warning, and refusals. The run walks several
// array size settings, one of them above the index space, and checks each
// result field by field while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top
  import idxq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IB          = INDEX_BITS_DEFAULT;
  localparam int SPACE       = 1 << IB;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_GAP   = 6;

  typedef struct {
    logic [IB-1:0] idx;
    logic          reused;
    status_t       st;
    logic [IB:0]   cnt;
  } slot_grant_t;

  // Tracks the allocator state and the results still owed by the block.
  class index_ledger;
    logic [ARRAY_SIZE_W-1:0] array_size = '0;
    logic [IB:0]             fresh_next = '0;
    logic [IB:0]             in_use     = '0;
    logic [IB-1:0]           reuse_fifo[$];
    logic [IB-1:0]           live_ids[$];
    slot_grant_t             pending_grants[$];
    int                      errors = 0;

    function void note_request(logic mode, logic [IB-1:0] rel);
      slot_grant_t g;
      g.idx    = '0;
      g.reused = 1'b0;
      g.st     = ST_OK;
      if (mode == MODE_ALLOC) begin
        if (reuse_fifo.size() != 0) begin
          g.idx    = reuse_fifo.pop_front();
          g.reused = 1'b1;
          in_use++;
          live_ids.push_back(g.idx);
        end else if (fresh_next >= SPACE) begin
          g.st = ST_ALLOC_REFUSED;
        end else begin
          g.idx = fresh_next[IB-1:0];
          fresh_next++;
          // Exhaustion wins when both limits are hit by the same index.
          if (fresh_next == SPACE)
            g.st = ST_SPACE_EXHAUSTED;
          else if (array_size != 0 && fresh_next == array_size)
            g.st = ST_ARRAY_REACHED;
          in_use++;
          live_ids.push_back(g.idx);
        end
      end else begin
        if (in_use == 0 || reuse_fifo.size() >= SPACE) begin
          g.st = ST_RELEASE_REFUSED;
        end else begin
          in_use--;
          reuse_fifo.push_back(rel);
        end
      end
      g.cnt = in_use;
      pending_grants.push_back(g);
    endfunction

    task report(string msg);
      if (errors < 40)
        $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_grant(logic [IB-1:0] idx, logic reused, logic [STATUS_W-1:0] st,
                     logic [IB:0] cnt);
      slot_grant_t g;
      if (pending_grants.size() == 0) begin
        report($sformatf("result with nothing pending: idx=%0d status=%0d", idx, st));
        return;
      end
      g = pending_grants.pop_front();
      if (idx !== g.idx)
        report($sformatf("granted_index %0d, expected %0d", idx, g.idx));
      if (reused !== g.reused)
        report($sformatf("reused %0b, expected %0b", reused, g.reused));
      if (st !== g.st)
        report($sformatf("status %0d, expected %s", st, g.st.name()));
      if (cnt !== g.cnt)
        report($sformatf("active_count %0d, expected %0d", cnt, g.cnt));
    endtask

    task flush_check();
      if (pending_grants.size() != 0)
        report($sformatf("%0d results never arrived", pending_grants.size()));
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_wr_en = 1'b0;
  logic [ARRAY_SIZE_W-1:0] cfg_wr_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_mode = MODE_ALLOC;
  logic [IB-1:0]           in_released_index = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [IB-1:0]           out_granted_index;
  logic                    out_reused;
  logic [STATUS_W-1:0]     out_status;
  logic [IB:0]             out_active_count;

  index_ledger ledger = new;
  int          burst_left = 0;
  bit          hold_off_req = 1'b0;
  bit          hold_off_done = 1'b0;
  int          cycle_count = 0;

  index_allocator_with_reuse_queue_unit #(.INDEX_BITS(IB)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_released_index (in_released_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_granted_index (out_granted_index),
    .out_reused        (out_reused),
    .out_status        (out_status),
    .out_active_count  (out_active_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      ledger.check_grant(out_granted_index, out_reused, out_status, out_active_count);
  end

  // Result side: a stall style that is drawn anew at random, plus one long
  // hold-off so that the block fills up and pushes back on the sender.
  initial begin
    int style;
    int style_age;
    style = 0;
    style_age = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_done = 1'b1;
      end
      if (style_age == 0) begin
        style = $urandom_range(0, 3);
        style_age = 50;
      end
      style_age--;
      case (style)
        0: out_stall = 1'b0;
        1: out_stall = ($urandom_range(0, 99) < 30);
        2: out_stall = ~out_stall;
        default: out_stall = ($urandom_range(0, 99) < 75);
      endcase
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offers one transaction and returns once it has been accepted. The sender
  // works in bursts with idle gaps between them.
  task automatic send_request(input logic mode, input logic [IB-1:0] rel);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid = 1'b1;
    in_mode = mode;
    in_released_index = rel;
    do @(posedge clk); while (in_stall);
    ledger.note_request(mode, rel);
  endtask

  // Mostly releases an index that is really in use, sometimes any index.
  function automatic logic [IB-1:0] pick_release();
    int k;
    if (ledger.live_ids.size() != 0 && $urandom_range(0, 99) < 85) begin
      k = $urandom_range(0, ledger.live_ids.size() - 1);
      pick_release = ledger.live_ids[k];
      ledger.live_ids.delete(k);
    end else begin
      pick_release = IB'($urandom_range(0, SPACE - 1));
    end
  endfunction

  task automatic random_request(input int alloc_pct);
    logic mode;
    mode = ($urandom_range(0, 99) < alloc_pct) ? MODE_ALLOC : MODE_RELEASE;
    if (mode == MODE_RELEASE)
      send_request(mode, pick_release());
    else
      send_request(mode, IB'($urandom_range(0, SPACE - 1)));
  endtask

  // Alternating allocate-heavy and release-heavy stretches keep the reuse
  // queue swinging between empty and deep.
  task automatic run_mixed(input int n);
    for (int i = 0; i < n; i++)
      random_request(((i / 40) % 2 == 0) ? 70 : 30);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (ledger.pending_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_array_size(input logic [ARRAY_SIZE_W-1:0] value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    ledger.array_size = value;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed opening with a small array size.
    write_array_size(ARRAY_SIZE_W'(3));
    send_request(MODE_RELEASE, '1);      // release refused while nothing is in use
    send_request(MODE_ALLOC, '0);
    send_request(MODE_ALLOC, '1);
    send_request(MODE_ALLOC, '0);        // third fresh index reaches the array size
    send_request(MODE_RELEASE, '0);
    send_request(MODE_RELEASE, '1);
    send_request(MODE_ALLOC, '1);        // reuses index 0
    send_request(MODE_ALLOC, '0);        // reuses the all-ones index
    send_request(MODE_ALLOC, '0);        // fresh index past the array size
    send_request(MODE_RELEASE, 10'd5);
    send_request(MODE_RELEASE, 10'h2AA);
    send_request(MODE_RELEASE, 10'h155);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_ALLOC, '0);
    repeat (4) send_request(MODE_RELEASE, 10'd7);
    send_request(MODE_RELEASE, 10'd9);   // count is back to zero
    settle();

    // Warning disabled; the long hold-off falls in this stretch.
    write_array_size(ARRAY_SIZE_W'(0));
    hold_off_req = 1'b1;
    run_mixed(220);
    settle();

    write_array_size(ARRAY_SIZE_W'(ledger.fresh_next + $urandom_range(5, 30)));
    run_mixed(220);
    settle();

    // Array size above the index space, so that warning never fires.
    write_array_size('1);
    run_mixed(240);
    settle();

    ledger.flush_check();
    if (ledger.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- index_allocator_with_reuse_queue_unit.f -----
rtl/idxq_pkg.sv
rtl/idxq_mem.sv
rtl/idxq_core.sv
rtl/index_allocator_with_reuse_queue_unit.sv
tb/sv/tb_top.sv
